/* src/cfd_pkg.sv */
// Shared constants, types and states of the CAN frame deframer.
package cfd_pkg;

	localparam int WINDOW_DEPTH    = 32;
	localparam int IN_QUEUE_DEPTH  = 2;
	localparam int OUT_QUEUE_DEPTH = 4;

	localparam logic [7:0] HDR_BYTE  = 8'hA5;
	localparam logic [7:0] TAIL_BYTE = 8'h5A;
	localparam logic [7:0] EXT_FLAG  = 8'h10;
	localparam logic [7:0] NIBBLE    = 8'h0F;

	// byte as it leaves the front part, with its class
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       is_hdr;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  port;
		logic        extended;
		logic [31:0] frame_id;
		logic [3:0]  data_len;
		logic        has_data;
		logic [7:0]  data_byte;
		logic [3:0]  byte_index;
		logic        last;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HDR,
		ST_PORT,
		ST_FLAGS,
		ST_TAIL,
		ST_ID,
		ST_DATA,
		ST_NODATA
	} back_state_t;

endpackage

/* src/can_frame_deframer.sv */
// CAN frame deframer top level: input byte queue, window scanner and result queue.
// A byte waits in the input queue while a scan runs; a byte kept in the window starts a scan
// through the header, port, flags and tail reads and the id reads, more of them for an extended
// id; a complete frame then gives one result per data byte, or one without data, to the result
// queue. A bad header or tail drops one byte and the window is scanned again.
// Reset (arst_n low) empties both queues and the window at once; no clearing pass.
module can_frame_deframer #(
	parameter int WINDOW_DEPTH    = cfd_pkg::WINDOW_DEPTH,
	parameter int IN_QUEUE_DEPTH  = cfd_pkg::IN_QUEUE_DEPTH,
	parameter int OUT_QUEUE_DEPTH = cfd_pkg::OUT_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        pop,
	output logic        empty,
	output logic [3:0]  port,
	output logic        extended,
	output logic [31:0] frame_id,
	output logic [3:0]  data_len,
	output logic        has_data,
	output logic [7:0]  data_byte,
	output logic [3:0]  byte_index,
	output logic        last
);

	cfd_pkg::in_item_t item;
	logic              item_empty;
	logic              item_pop;
	logic              res_full;
	logic              res_push;
	cfd_pkg::res_t     res_in;
	cfd_pkg::res_t     res_out;
	logic [$bits(cfd_pkg::res_t)-1:0] res_rdata;

	cfd_front #(
		.IN_QUEUE_DEPTH(IN_QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.item_pop  (item_pop),
		.item_empty(item_empty),
		.item      (item)
	);

	cfd_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_empty(item_empty),
		.item      (item),
		.item_pop  (item_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	cfd_fifo #(
		.WIDTH($bits(cfd_pkg::res_t)),
		.DEPTH(OUT_QUEUE_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign res_out    = cfd_pkg::res_t'(res_rdata);
	assign port       = res_out.port;
	assign extended   = res_out.extended;
	assign frame_id   = res_out.frame_id;
	assign data_len   = res_out.data_len;
	assign has_data   = res_out.has_data;
	assign data_byte  = res_out.data_byte;
	assign byte_index = res_out.byte_index;
	assign last       = res_out.last;

endmodule

/* src/cfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/cfd_fifo.sv */
// Generic register queue with push/full and pop/empty sides.
module cfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

/* src/cfd_front.sv */
// Front part: takes received bytes, marks header bytes and queues them for the back part.
module cfd_front #(
	parameter int IN_QUEUE_DEPTH = cfd_pkg::IN_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        rx_byte,
	input  logic              item_pop,
	output logic              item_empty,
	output cfd_pkg::in_item_t item
);

	cfd_pkg::in_item_t in_item;
	logic [$bits(cfd_pkg::in_item_t)-1:0] q_rdata;

	always_comb begin
		in_item.rx_byte = rx_byte;
		in_item.is_hdr  = (rx_byte == cfd_pkg::HDR_BYTE);
	end

	cfd_fifo #(
		.WIDTH($bits(cfd_pkg::in_item_t)),
		.DEPTH(IN_QUEUE_DEPTH)
	) u_in_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (in_item),
		.full  (full),
		.pop   (item_pop),
		.rdata (q_rdata),
		.empty (item_empty)
	);

	assign item = cfd_pkg::in_item_t'(q_rdata);

endmodule

/* src/cfd_back.sv */
// Back part: keeps the byte window in RAM, scans it for frames and emits one result per transfer.
module cfd_back #(
	parameter int WINDOW_DEPTH = cfd_pkg::WINDOW_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_empty,
	input  cfd_pkg::in_item_t item,
	output logic              item_pop,
	input  logic              res_full,
	output logic              res_push,
	output cfd_pkg::res_t     res
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = AW + 1;

	cfd_pkg::back_state_t state_q, state_d;

	logic [AW-1:0] hd_q;
	logic [CW-1:0] fill_q;
	logic [3:0]    port_q;
	logic          ext_q;
	logic [3:0]    dlc_q;
	logic [4:0]    total_q;
	logic [31:0]   id_q;
	logic [1:0]    id_cnt_q;
	logic [3:0]    k_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic          fill_full;
	logic          ext_c;
	logic [3:0]    dlc_c;
	logic [4:0]    total_c;
	logic [CW-1:0] data_start;
	logic          last_data;
	logic          drop_one;
	logic          drop_total;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW-1:0] s;
		s = {1'b0, base} + off;
		if (s >= CW'(WINDOW_DEPTH)) begin
			s = s - CW'(WINDOW_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign fill_full  = (fill_q == CW'(WINDOW_DEPTH));
	assign ext_c      = (ram_rdata & cfd_pkg::EXT_FLAG) != 8'h00;
	assign dlc_c      = ram_rdata[3:0];
	assign total_c    = (ext_c ? 5'd8 : 5'd5) + {1'b0, dlc_c};
	assign data_start = ext_q ? CW'(7) : CW'(4);
	assign last_data  = (k_q == dlc_q - 4'd1);
	assign ram_waddr  = fill_full ? hd_q : wrap_add(hd_q, fill_q);

	cfd_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(item.rx_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cfd_pkg::ST_IDLE: begin
				if (!item_empty && (fill_q != '0 || item.is_hdr)) begin
					state_d = cfd_pkg::ST_SCAN;
				end
			end
			cfd_pkg::ST_SCAN: begin
				state_d = (fill_q == '0) ? cfd_pkg::ST_IDLE : cfd_pkg::ST_HDR;
			end
			cfd_pkg::ST_HDR: begin
				if (ram_rdata != cfd_pkg::HDR_BYTE) begin
					state_d = cfd_pkg::ST_SCAN;
				end else if (fill_q < CW'(3)) begin
					state_d = cfd_pkg::ST_IDLE;
				end else begin
					state_d = cfd_pkg::ST_PORT;
				end
			end
			cfd_pkg::ST_PORT: begin
				state_d = cfd_pkg::ST_FLAGS;
			end
			cfd_pkg::ST_FLAGS: begin
				state_d = (fill_q < CW'(total_c)) ? cfd_pkg::ST_IDLE : cfd_pkg::ST_TAIL;
			end
			cfd_pkg::ST_TAIL: begin
				state_d = (ram_rdata != cfd_pkg::TAIL_BYTE) ? cfd_pkg::ST_SCAN : cfd_pkg::ST_ID;
			end
			cfd_pkg::ST_ID: begin
				if (ext_q && id_cnt_q != 2'd3) begin
					state_d = cfd_pkg::ST_ID;
				end else if (dlc_q != 4'd0) begin
					state_d = cfd_pkg::ST_DATA;
				end else begin
					state_d = cfd_pkg::ST_NODATA;
				end
			end
			cfd_pkg::ST_DATA: begin
				if (!res_full && last_data) begin
					state_d = cfd_pkg::ST_IDLE;
				end
			end
			cfd_pkg::ST_NODATA: begin
				if (!res_full) begin
					state_d = cfd_pkg::ST_IDLE;
				end
			end
			default: state_d = cfd_pkg::ST_IDLE;
		endcase
	end

	// outputs and RAM control
	always_comb begin
		item_pop   = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = hd_q;
		res_push   = 1'b0;
		drop_one   = 1'b0;
		drop_total = 1'b0;
		case (state_q)
			cfd_pkg::ST_IDLE: begin
				if (!item_empty) begin
					item_pop = 1'b1;
					// a stray byte into an empty window is dropped right away
					ram_we   = (fill_q != '0) || item.is_hdr;
				end
			end
			cfd_pkg::ST_SCAN: begin
				ram_re = (fill_q != '0);
			end
			cfd_pkg::ST_HDR: begin
				if (ram_rdata != cfd_pkg::HDR_BYTE) begin
					drop_one = 1'b1;
				end else if (fill_q >= CW'(3)) begin
					ram_re    = 1'b1;
					ram_raddr = wrap_add(hd_q, CW'(1));
				end
			end
			cfd_pkg::ST_PORT: begin
				ram_re    = 1'b1;
				ram_raddr = wrap_add(hd_q, CW'(2));
			end
			cfd_pkg::ST_FLAGS: begin
				if (fill_q >= CW'(total_c)) begin
					ram_re    = 1'b1;
					ram_raddr = wrap_add(hd_q, CW'(total_c) - CW'(1));
				end
			end
			cfd_pkg::ST_TAIL: begin
				if (ram_rdata != cfd_pkg::TAIL_BYTE) begin
					drop_one = 1'b1;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = wrap_add(hd_q, CW'(3));
				end
			end
			cfd_pkg::ST_ID: begin
				if (ext_q && id_cnt_q != 2'd3) begin
					ram_re    = 1'b1;
					ram_raddr = wrap_add(hd_q, CW'(4) + CW'(id_cnt_q));
				end else if (dlc_q != 4'd0) begin
					ram_re    = 1'b1;
					ram_raddr = wrap_add(hd_q, data_start);
				end
			end
			cfd_pkg::ST_DATA: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (last_data) begin
						drop_total = 1'b1;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = wrap_add(hd_q, data_start + CW'(k_q) + CW'(1));
					end
				end
			end
			cfd_pkg::ST_NODATA: begin
				if (!res_full) begin
					res_push   = 1'b1;
					drop_total = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.port       = port_q;
		res.extended   = ext_q;
		res.frame_id   = id_q;
		res.data_len   = dlc_q;
		res.has_data   = (state_q == cfd_pkg::ST_DATA);
		res.data_byte  = (state_q == cfd_pkg::ST_DATA) ? ram_rdata : 8'h00;
		res.byte_index = (state_q == cfd_pkg::ST_DATA) ? k_q : 4'd0;
		res.last       = (state_q == cfd_pkg::ST_NODATA) || last_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfd_pkg::ST_IDLE;
			hd_q    <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				// full window: overwrite the oldest byte and advance the head
				if (fill_full) begin
					hd_q <= wrap_add(hd_q, CW'(1));
				end else begin
					fill_q <= fill_q + CW'(1);
				end
			end else if (state_q == cfd_pkg::ST_SCAN && fill_q == '0) begin
				hd_q <= '0;
			end
			if (drop_one) begin
				hd_q   <= wrap_add(hd_q, CW'(1));
				fill_q <= fill_q - CW'(1);
			end
			if (drop_total) begin
				hd_q   <= wrap_add(hd_q, CW'(total_q));
				fill_q <= fill_q - CW'(total_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cfd_pkg::ST_PORT: begin
				port_q <= ram_rdata[3:0];
			end
			cfd_pkg::ST_FLAGS: begin
				ext_q   <= ext_c;
				dlc_q   <= dlc_c;
				total_q <= total_c;
			end
			cfd_pkg::ST_TAIL: begin
				id_cnt_q <= 2'd0;
			end
			cfd_pkg::ST_ID: begin
				id_q     <= ext_q ? {id_q[23:0], ram_rdata} : {24'h000000, ram_rdata};
				id_cnt_q <= id_cnt_q + 2'd1;
				k_q      <= 4'd0;
			end
			cfd_pkg::ST_DATA: begin
				if (res_push && !last_data) begin
					k_q <= k_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(WINDOW_DEPTH))
		else $error("window fill beyond depth");

	a_push_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full &&
			(state_q == cfd_pkg::ST_DATA || state_q == cfd_pkg::ST_NODATA))
		else $error("result transfer outside emit states");

	a_hdr_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cfd_pkg::ST_HDR |-> $past(state_q) == cfd_pkg::ST_SCAN)
		else $error("header check without a read issued");

	a_drop_fits: assert property (@(posedge clk) disable iff (!arst_n)
		drop_total |-> fill_q >= CW'(total_q))
		else $error("frame drop larger than window fill");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> state_q == cfd_pkg::ST_IDLE && !item_empty)
		else $error("byte taken while a scan is running");
`endif

endmodule
